@@ hdl/ifd_pkg.sv @@
// ifd_pkg: shared types and constants for the serial sensor frame deframer.
// No dependencies; used by every module under hdl/.
package ifd_pkg;

  localparam int WIN_LEN   = 10;  // bytes held ahead of the checksum byte
  localparam int PAY_LEN   = 8;   // payload bytes per frame
  localparam int NUM_KINDS = 6;
  localparam int KIND_W    = 3;
  localparam int FILL_W    = 4;
  localparam int IDX_W     = 3;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_HEADER = 3'd0;
  localparam logic [IDX_W-1:0] REG_TIME   = 3'd1;
  localparam logic [IDX_W-1:0] REG_ACCEL  = 3'd2;
  localparam logic [IDX_W-1:0] REG_GYRO   = 3'd3;
  localparam logic [IDX_W-1:0] REG_ANGLE  = 3'd4;
  localparam logic [IDX_W-1:0] REG_MAG    = 3'd5;
  localparam logic [IDX_W-1:0] REG_QUAT   = 3'd6;

  localparam logic [7:0] HEADER_RST = 8'd85;
  localparam logic [NUM_KINDS-1:0][7:0] CODES_RST =
    {8'd89, 8'd84, 8'd83, 8'd82, 8'd81, 8'd80};

  // entry 0 is the oldest byte
  typedef logic [WIN_LEN-1:0][7:0] win_t;

  typedef struct packed {
    logic [7:0]                  header;
    logic [NUM_KINDS-1:0][7:0]   codes;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [PAY_LEN*8-1:0]    payload;
  } res_t;

endpackage

@@ hdl/ifd_window.sv @@
// ifd_window: sliding window of the last ten received bytes, fill count and
// running byte sum of the window. Depends on ifd_pkg.
module ifd_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift,
  input  logic [7:0]        rx_byte,
  output ifd_pkg::win_t     win,
  output logic              full,
  output logic [7:0]        win_sum
);

  ifd_pkg::win_t                   window;
  logic [ifd_pkg::FILL_W-1:0]      fill_count;
  logic [7:0]                      sum;

  // window starts all zero, so the oldest byte can always be taken out
  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      fill_count <= '0;
      sum        <= '0;
    end else if (shift) begin
      window <= {rx_byte, window[ifd_pkg::WIN_LEN-1:1]};
      sum    <= sum + rx_byte - window[0];
      if (fill_count != ifd_pkg::FILL_W'(ifd_pkg::WIN_LEN)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  assign win     = window;
  assign full    = (fill_count == ifd_pkg::FILL_W'(ifd_pkg::WIN_LEN));
  assign win_sum = sum;

endmodule

@@ hdl/ifd_check.sv @@
// ifd_check: tests window plus new byte as one frame and picks the kind.
// Depends on ifd_pkg.
module ifd_check (
  input  ifd_pkg::win_t     win,
  input  logic              full,
  input  logic [7:0]        win_sum,
  input  logic [7:0]        rx_byte,
  input  ifd_pkg::cfg_t     cfg,
  output logic              hit,
  output ifd_pkg::res_t     res
);

  logic                          frame_ok;
  logic                          kind_found;
  logic [ifd_pkg::KIND_W-1:0]    kind;

  assign frame_ok = full && (win[0] == cfg.header) && (win_sum == rx_byte);

  // scan from the top so the lowest matching kind wins
  always_comb begin
    kind_found = 1'b0;
    kind       = '0;
    for (int i = ifd_pkg::NUM_KINDS - 1; i >= 0; i--) begin
      if (win[1] == cfg.codes[i]) begin
        kind_found = 1'b1;
        kind       = ifd_pkg::KIND_W'(i);
      end
    end
  end

  assign hit         = frame_ok && kind_found;
  assign res.kind    = kind;
  assign res.payload = win[ifd_pkg::PAY_LEN+1:2];

endmodule

@@ hdl/ifd_out_buf.sv @@
// ifd_out_buf: result register with a skid stage behind it.
// Depends on ifd_pkg.
module ifd_out_buf (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          res_valid,
  input  ifd_pkg::res_t                 res,
  output logic                          busy,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ifd_pkg::KIND_W-1:0]    frame_kind,
  output logic [ifd_pkg::PAY_LEN*8-1:0] payload
);

  logic            head_valid;
  ifd_pkg::res_t   head;
  logic            skid_valid;
  ifd_pkg::res_t   skid;
  logic            load;

  assign load = !head_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (load) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      head <= skid_valid ? skid : res;
    end
    if (!load && res_valid) begin
      skid <= res;
    end
  end

  // input side holds off only while the skid stage is occupied
  assign busy       = skid_valid;
  assign out_valid  = head_valid;
  assign frame_kind = head.kind;
  assign payload    = head.payload;

endmodule

@@ hdl/imu_frame_deframer_core.sv @@
// imu_frame_deframer_core: top level of the serial sensor frame deframer.
// Depends on ifd_pkg, ifd_window, ifd_check, ifd_out_buf.
//
//   channel | handshake            | payload
//   --------+----------------------+-----------------------------
//   input   | in_valid / in_stall  | rx_byte[7:0]
//   output  | out_valid / out_stall| frame_kind[2:0], payload[63:0]
//   config  | cfg_valid / cfg_ready| cfg_index[2:0], cfg_data[7:0]
//
// One byte per cycle while in_stall is low; each frame result is registered.
// The frame check is one pass of compares over the window and a running sum.
// in_stall rises only when a result waits in the skid stage behind a stalled
// output register. rst (synchronous) empties the window, restores registers.
// Config writes are always ready; indexes above six are dropped.
module imu_frame_deframer_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    rx_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ifd_pkg::KIND_W-1:0]    frame_kind,
  output logic [ifd_pkg::PAY_LEN*8-1:0] payload,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ifd_pkg::IDX_W-1:0]     cfg_index,
  input  logic [7:0]                    cfg_data
);

  ifd_pkg::cfg_t   cfg;
  ifd_pkg::win_t   win;
  ifd_pkg::res_t   res;
  logic            full;
  logic [7:0]      win_sum;
  logic            hit;
  logic            busy;
  logic            accept;
  logic [ifd_pkg::IDX_W-1:0] code_idx;

  assign cfg_ready = 1'b1;
  assign code_idx  = cfg_index - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header <= ifd_pkg::HEADER_RST;
      cfg.codes  <= ifd_pkg::CODES_RST;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == ifd_pkg::REG_HEADER) begin
        cfg.header <= cfg_data;
      end else if (cfg_index inside {[ifd_pkg::REG_TIME:ifd_pkg::REG_QUAT]}) begin
        cfg.codes[code_idx] <= cfg_data;
      end
    end
  end

  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  ifd_window u_window (
    .clk     (clk),
    .rst     (rst),
    .shift   (accept),
    .rx_byte (rx_byte),
    .win     (win),
    .full    (full),
    .win_sum (win_sum)
  );

  ifd_check u_check (
    .win     (win),
    .full    (full),
    .win_sum (win_sum),
    .rx_byte (rx_byte),
    .cfg     (cfg),
    .hit     (hit),
    .res     (res)
  );

  ifd_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (accept && hit),
    .res        (res),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_kind (frame_kind),
    .payload    (payload)
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for imu_frame_deframer_core, serial bytes in, frame words out.
// Depends on ifd_pkg and the deframer RTL. Keeps its own shadow of the window and the type codes.
module testbench;

  localparam int IDLE_MAX    = 5;
  localparam int SETTLE      = 6;     // cycles after the last frame word before a register write
  localparam int STUCK_LIMIT = 2000;  // cycles with no word moved on any channel
  localparam int LONG_HOLD   = 300;
  localparam logic [ifd_pkg::IDX_W-1:0] REG_NONE = 3'd7;  // unmapped index, write is dropped

  logic                           clk        = 1'b0;
  logic                           rst        = 1'b1;
  logic                           in_valid   = 1'b0;
  logic                           in_stall;
  logic [7:0]                     rx_byte    = 8'h00;
  logic                           out_valid;
  logic                           out_stall  = 1'b0;
  logic [ifd_pkg::KIND_W-1:0]     frame_kind;
  logic [ifd_pkg::PAY_LEN*8-1:0]  payload;
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  logic [ifd_pkg::IDX_W-1:0]      cfg_index  = '0;
  logic [7:0]                     cfg_data   = 8'h00;

  // shadow of the block
  logic [7:0]     hdr_shadow;
  logic [7:0]     code_shadow [ifd_pkg::NUM_KINDS];
  logic [7:0]     window_shadow [ifd_pkg::WIN_LEN];
  int unsigned    window_fill;
  ifd_pkg::res_t  frames_due [$];

  bit sender_idles   = 1'b1;
  bit receiver_idles = 1'b1;
  int long_hold      = 0;
  int errors         = 0;
  int bytes_sent     = 0;
  int frames_seen    = 0;
  int reg_writes     = 0;
  int stuck_cycles   = 0;

  imu_frame_deframer_core DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame_kind (frame_kind),
    .payload    (payload),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void reset_shadow();
    hdr_shadow = ifd_pkg::HEADER_RST;
    for (int k = 0; k < ifd_pkg::NUM_KINDS; k++) code_shadow[k] = ifd_pkg::CODES_RST[k];
    for (int i = 0; i < ifd_pkg::WIN_LEN; i++) window_shadow[i] = 8'h00;
    window_fill = 0;
  endfunction

  // Test the window plus the new byte as a frame, then slide the window.
  function automatic void track_byte(input logic [7:0] b);
    logic [7:0]     sum;
    ifd_pkg::res_t  r;
    int             k;
    sum = 8'h00;
    k = -1;
    if (window_fill >= ifd_pkg::WIN_LEN && window_shadow[0] == hdr_shadow) begin
      for (int i = 0; i < ifd_pkg::WIN_LEN; i++) sum += window_shadow[i];
      if (sum == b) begin
        // scan downward so the lowest matching kind is the one kept
        for (int i = ifd_pkg::NUM_KINDS - 1; i >= 0; i--)
          if (window_shadow[1] == code_shadow[i]) k = i;
        if (k >= 0) begin
          r.kind = ifd_pkg::KIND_W'(k);
          for (int i = 0; i < ifd_pkg::PAY_LEN; i++)
            r.payload[8*i +: 8] = window_shadow[2+i];
          frames_due.push_back(r);
        end
      end
    end
    for (int i = 0; i < ifd_pkg::WIN_LEN - 1; i++) window_shadow[i] = window_shadow[i+1];
    window_shadow[ifd_pkg::WIN_LEN-1] = b;
    if (window_fill < ifd_pkg::WIN_LEN) window_fill++;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = sender_idles ? $urandom_range(0, IDLE_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    track_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] hdr, input logic [7:0] type_b,
                            input logic [63:0] body, input logic [7:0] sum_err);
    logic [7:0] sum;
    sum = hdr + type_b;
    send_byte(hdr);
    send_byte(type_b);
    for (int i = 0; i < ifd_pkg::PAY_LEN; i++) begin
      send_byte(body[8*i +: 8]);
      sum += body[8*i +: 8];
    end
    send_byte(sum + sum_err);
  endtask

  // Stop offering bytes and let every pending frame word come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // cfg_valid stays high across back-to-back writes; only the last one drops it
  task automatic write_reg(input logic [ifd_pkg::IDX_W-1:0] idx, input logic [7:0] val,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    if (idx == ifd_pkg::REG_HEADER) hdr_shadow = val;
    else if (idx <= ifd_pkg::REG_QUAT) code_shadow[idx - ifd_pkg::REG_TIME] = val;
    reg_writes++;
  endtask

  // vals[0] is the header byte, vals[k] the type code of kind k-1
  task automatic load_regs(input logic [ifd_pkg::NUM_KINDS:0][7:0] vals);
    for (int i = 0; i <= ifd_pkg::NUM_KINDS; i++)
      write_reg(ifd_pkg::IDX_W'(i), vals[i], i == ifd_pkg::NUM_KINDS);
  endtask

  task automatic stream_traffic(input int budget);
    int first;
    int pick;
    first = bytes_sent;
    while (bytes_sent - first < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 12)
        send_byte(8'($urandom));
      else if (pick < 22)
        send_frame(hdr_shadow, code_shadow[$urandom_range(0, ifd_pkg::NUM_KINDS-1)],
                   {$urandom, $urandom}, 8'($urandom_range(1, 255)));
      else if (pick < 30)
        send_frame(hdr_shadow, 8'($urandom), {$urandom, $urandom}, 8'h00);
      else
        send_frame(hdr_shadow, code_shadow[$urandom_range(0, ifd_pkg::NUM_KINDS-1)],
                   {$urandom, $urandom}, 8'h00);
    end
  endtask

  // Right after reset the window holds zeros; nothing may be tested before ten bytes.
  task automatic test_unfilled_window();
    write_reg(ifd_pkg::REG_HEADER, 8'h00, 1'b0);
    write_reg(ifd_pkg::REG_TIME, 8'h00, 1'b1);
    repeat (ifd_pkg::WIN_LEN + 2) send_byte(8'h00);
    drain();
  endtask

  task automatic test_each_kind();
    logic [63:0] body;
    write_reg(ifd_pkg::REG_HEADER, ifd_pkg::HEADER_RST, 1'b0);
    write_reg(ifd_pkg::REG_TIME, ifd_pkg::CODES_RST[0], 1'b1);
    for (int k = 0; k < ifd_pkg::NUM_KINDS; k++) begin
      case (k)
        0:       body = '1;
        1:       body = '0;
        2:       body = 64'h0123_4567_89ab_cdef;
        default: body = {$urandom, $urandom};
      endcase
      send_frame(hdr_shadow, code_shadow[k], body, 8'h00);
    end
    drain();
  endtask

  task automatic test_rejected_frames();
    send_frame(hdr_shadow, code_shadow[2], {$urandom, $urandom}, 8'h01);   // bad sum
    send_frame(hdr_shadow, 8'h00, {$urandom, $urandom}, 8'h00);            // unknown type
    send_frame(hdr_shadow ^ 8'h01, code_shadow[1], {$urandom, $urandom}, 8'h00);
    drain();
  endtask

  task automatic test_shared_codes();
    for (int i = 0; i <= ifd_pkg::NUM_KINDS; i++)
      write_reg(ifd_pkg::IDX_W'(i), 8'hff, 1'b0);
    write_reg(REG_NONE, 8'($urandom), 1'b1);
    send_frame(8'hff, 8'hff, '1, 8'h00);
    drain();
    write_reg(ifd_pkg::REG_TIME, 8'h00, 1'b1);
    send_frame(8'hff, 8'hff, {$urandom, $urandom}, 8'h00);
    drain();
  endtask

  // Receiver holds off while good frames keep coming, so the input side must stall.
  task automatic test_output_backpressure();
    load_regs({ifd_pkg::CODES_RST, ifd_pkg::HEADER_RST});
    sender_idles = 1'b0;
    long_hold    = LONG_HOLD;
    repeat (10)
      send_frame(hdr_shadow, code_shadow[$urandom_range(0, ifd_pkg::NUM_KINDS-1)],
                 {$urandom, $urandom}, 8'h00);
    drain();
    sender_idles = 1'b1;
  endtask

  task automatic test_random_traffic();
    logic [ifd_pkg::NUM_KINDS:0][7:0] vals;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: vals = {ifd_pkg::CODES_RST, ifd_pkg::HEADER_RST};
        1: for (int i = 0; i <= ifd_pkg::NUM_KINDS; i++) vals[i] = 8'($urandom);
        2: vals = {8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0, 8'd0};
        default: vals = {8'd250, 8'd251, 8'd252, 8'd253, 8'd254, 8'd255, 8'd255};
      endcase
      load_regs(vals);
      sender_idles   = ($urandom_range(0, 3) != 0);
      receiver_idles = ($urandom_range(0, 3) != 0);
      stream_traffic(100);
      drain();
    end
  endtask

  // receiver side: per-word random hold-off, plus the long hold when requested
  initial begin : result_sink
    int wait_left;
    wait_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        wait_left = receiver_idles ? $urandom_range(0, IDLE_MAX) : 0;
      else if (wait_left > 0)
        wait_left--;
      if (long_hold > 0) long_hold--;
      out_stall <= (wait_left > 0) || (long_hold > 0);
    end
  end

  initial begin : frame_checker
    ifd_pkg::res_t want;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        frames_seen++;
        if (frames_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected frame word, expected none, actual kind %0d payload %h",
                   $time, frame_kind, payload);
        end else begin
          want = frames_due.pop_front();
          if (frame_kind !== want.kind) begin
            errors++;
            $display("%0t: frame_kind mismatch, expected %0d actual %0d",
                     $time, want.kind, frame_kind);
          end
          if (payload !== want.payload) begin
            errors++;
            $display("%0t: payload mismatch, expected %h actual %h",
                     $time, want.payload, payload);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      stuck_cycles <= 0;
    else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d frame words outstanding",
               $time, STUCK_LIMIT, frames_due.size());
      $display("imu_frame_deframer_core verification failed");
      $finish;
    end else
      stuck_cycles <= stuck_cycles + 1;
  end

  initial begin
    reset_shadow();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_unfilled_window();
    test_each_kind();
    test_rejected_frames();
    test_shared_codes();
    test_output_backpressure();
    test_random_traffic();
    drain();
    $display("Streamed %0d bytes, checked %0d frame words, %0d register writes.",
             bytes_sent, frames_seen, reg_writes);
    $display("Covered all kinds, bad sums and headers, unknown and shared codes, long hold-off.");
    if (errors == 0) begin
      $display("imu_frame_deframer_core verification clean");
    end else begin
      $display("imu_frame_deframer_core verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/ifd_pkg.sv
hdl/ifd_window.sv
hdl/ifd_check.sv
hdl/ifd_out_buf.sv
hdl/imu_frame_deframer_core.sv
sim/testbench.sv
